@@ rtl/mcptg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcptg_pkg
// Shared types and constants of the multi-channel pulse train generator.
// ----------------------------------------------------------------------------
package mcptg_pkg;

    localparam int CHANNELS_DEF     = 11;
    localparam int OUT_BITS         = 11;
    localparam int CNT_W            = 16;
    localparam int HP_W             = 16;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 16;
    localparam logic [HP_W-1:0] HP_RESET = 16'd200;
    localparam logic ACTIVE_LOW_RESET    = 1'b1;

    typedef enum logic [1:0] {
        FUNC_TICK      = 2'd0,
        FUNC_START     = 2'd1,
        FUNC_START_INV = 2'd2,
        FUNC_SET_LEVEL = 2'd3
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEFAULT_HP = 2'd0,
        REG_ACTIVE_LOW = 2'd1
    } t_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [CNT_W-1:0] rem;
        logic [HP_W-1:0]  hp;
        logic [HP_W-1:0]  cd;
        logic             rp;
        logic             inv;
        logic             ph;
    } t_chan;

    typedef struct packed {
        logic we;
        logic val;
    } t_lvl_upd;

endpackage
`default_nettype wire

@@ rtl/mcptg_tick_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcptg_tick_unit
// Shared tick update: advances one channel's countdown, phase and count.
// ----------------------------------------------------------------------------
module mcptg_tick_unit (
    input  mcptg_pkg::t_chan    i_chan,
    output mcptg_pkg::t_chan    o_chan,
    output mcptg_pkg::t_lvl_upd o_lvl
);
    import mcptg_pkg::*;

    logic w_ph;

    always_comb begin
        o_chan = i_chan;
        o_lvl  = '0;
        w_ph   = i_chan.rp ? 1'b1 : ~i_chan.ph;
        if (i_chan.rem != '0) begin
            if (i_chan.cd != '0) begin
                o_chan.cd = i_chan.cd - 1'b1;
            end else begin
                o_chan.rp  = 1'b0;
                o_chan.ph  = w_ph;
                o_lvl.we   = 1'b1;
                o_lvl.val  = w_ph ^ i_chan.inv;
                o_chan.cd  = i_chan.hp;
                if (!w_ph) begin
                    o_chan.rem = i_chan.rem - 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/multi_channel_pulse_train_generator_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_channel_pulse_train_generator_unit
// Pulse burst generator on CHANNELS outputs, timed by tick commands.
//
// Input channel (i_in_valid / o_in_stall) takes one command transaction:
// tick, start, inverted start or direct level write. Every command gives one
// result transaction on the output channel (o_out_valid / i_out_stall) with
// the logical levels, pin levels, busy mask and a reject flag.
// A start or level write goes from acceptance through the done state to the
// result register. A tick first walks the channels one per cycle through one
// shared update unit. o_in_stall is high while a command is in work.
// The result register holds while the receiver stalls; a finished command
// waits there, and a following command is taken meanwhile but completes
// only once the register is free.
// Configuration writes (o_cfg_ready always high) are to be made by the user
// while idle; the block does not enforce it. Index 0 default half period,
// index 1 active-low pin polarity; other indexes are ignored.
// Reset clears all channel state and levels, sets the default half period
// to 200 and the polarity to active low.
// ----------------------------------------------------------------------------
module multi_channel_pulse_train_generator_unit #(
    parameter int CHANNELS = mcptg_pkg::CHANNELS_DEF
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_in_valid,
    output logic                                  o_in_stall,
    input  wire  [1:0]                            i_func,
    input  wire  [3:0]                            i_channel,
    input  wire  [mcptg_pkg::CNT_W-1:0]           i_pulse_count,
    input  wire  [mcptg_pkg::HP_W-1:0]            i_half_period,
    input  wire                                   i_level,
    output logic                                  o_out_valid,
    input  wire                                   i_out_stall,
    output logic [mcptg_pkg::OUT_BITS-1:0]        o_logical_levels,
    output logic [mcptg_pkg::OUT_BITS-1:0]        o_pin_levels,
    output logic [mcptg_pkg::OUT_BITS-1:0]        o_busy_mask,
    output logic                                  o_rejected,
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire  [mcptg_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [mcptg_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import mcptg_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int EXT_W = (CHANNELS > OUT_BITS) ? CHANNELS : OUT_BITS;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_rej, n_rej;
    logic             r_out_valid, n_out_valid;
    logic [OUT_BITS-1:0] r_log, n_log, r_pin, n_pin, r_busy_o, n_busy_o;
    logic             r_out_rej, n_out_rej;

    t_chan            r_chan [CHANNELS];
    logic [CHANNELS-1:0] r_level;
    logic [HP_W-1:0]  r_def_hp;
    logic             r_active_low;

    t_func            w_func;
    logic             w_accept;
    logic             w_ch_ok;
    logic [IDX_W-1:0] w_ch_idx;
    logic             w_start_ok;
    logic             w_set_ok;
    logic             w_out_free;
    t_chan            w_upd;
    t_lvl_upd         w_lvl;
    t_chan            w_start_val;
    logic [CHANNELS-1:0] w_busy;
    logic [EXT_W-1:0] w_lvl_ext, w_busy_ext, w_pin_ext, w_mask_ext;

    assign w_func     = t_func'(i_func);
    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_ch_ok    = ({1'b0, i_channel} < 5'(CHANNELS));
    assign w_ch_idx   = i_channel[IDX_W-1:0];
    assign w_start_ok = w_accept && w_ch_ok
                        && (w_func == FUNC_START || w_func == FUNC_START_INV);
    assign w_set_ok   = w_accept && w_ch_ok && (w_func == FUNC_SET_LEVEL);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    mcptg_tick_unit u_tick (
        .i_chan (r_chan[r_idx]),
        .o_chan (w_upd),
        .o_lvl  (w_lvl)
    );

    always_comb begin
        w_start_val     = r_chan[w_ch_idx];
        w_start_val.rem = (i_pulse_count == '0) ? CNT_W'(1) : i_pulse_count;
        w_start_val.hp  = (i_half_period == '0) ? r_def_hp : i_half_period;
        w_start_val.cd  = '0;
        w_start_val.rp  = 1'b1;
        w_start_val.inv = (w_func == FUNC_START_INV);
    end

    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            w_busy[i] = (r_chan[i].rem != '0);
        end
    end

    assign w_lvl_ext  = EXT_W'(r_level);
    assign w_busy_ext = EXT_W'(w_busy);
    assign w_mask_ext = EXT_W'({CHANNELS{1'b1}});
    assign w_pin_ext  = r_active_low ? (~w_lvl_ext & w_mask_ext) : w_lvl_ext;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_rej       = r_rej;
        n_out_valid = r_out_valid && i_out_stall;
        n_log       = r_log;
        n_pin       = r_pin;
        n_busy_o    = r_busy_o;
        n_out_rej   = r_out_rej;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_idx = '0;
                    n_rej = (w_func != FUNC_TICK) && !w_ch_ok;
                    n_state = (w_func == FUNC_TICK) ? ST_WALK : ST_DONE;
                end
            end
            ST_WALK: begin
                if (r_idx == IDX_W'(CHANNELS - 1)) begin
                    n_state = ST_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_log       = w_lvl_ext[OUT_BITS-1:0];
                    n_pin       = w_pin_ext[OUT_BITS-1:0];
                    n_busy_o    = w_busy_ext[OUT_BITS-1:0];
                    n_out_rej   = r_rej;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_rej       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_rej       <= n_rej;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_log     <= n_log;
        r_pin     <= n_pin;
        r_busy_o  <= n_busy_o;
        r_out_rej <= n_out_rej;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_chan[i] <= '0;
            end
            r_level <= '0;
        end else begin
            if (w_start_ok) begin
                r_chan[w_ch_idx] <= w_start_val;
            end
            if (r_state == ST_WALK) begin
                r_chan[r_idx] <= w_upd;
            end
            if (w_set_ok) begin
                r_level[w_ch_idx] <= i_level;
            end else if (r_state == ST_WALK && w_lvl.we) begin
                r_level[r_idx] <= w_lvl.val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_hp     <= HP_RESET;
            r_active_low <= ACTIVE_LOW_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_DEFAULT_HP) begin
                r_def_hp <= i_cfg_data[HP_W-1:0];
            end else if (i_cfg_index == REG_ACTIVE_LOW) begin
                r_active_low <= i_cfg_data[0];
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_logical_levels = r_log;
    assign o_pin_levels     = r_pin;
    assign o_busy_mask      = r_busy_o;
    assign o_rejected       = r_out_rej;

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start_ok |=> w_busy[$past(w_ch_idx)])
        else $error("started channel not busy");

    a_tick_no_rej: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_func == FUNC_TICK) |=> !r_rej)
        else $error("tick flagged as rejected");

    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_idx <= IDX_W'(CHANNELS - 1)))
        else $error("channel walk index out of range");

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-channel pulse train generator. Commands
// go through a valid/stall channel and are mirrored by a behavioral copy of
// the generator, which queues the expected levels, pin levels, busy mask and
// reject flag. A monitor compares each result transaction with the oldest
// entry. Directed tests cover level writes, rejects, bursts and register
// extremes. Random phases under several register settings follow, with gaps
// on the sender and stalls on the receiver.
// ----------------------------------------------------------------------------
module tb_top;
    import mcptg_pkg::*;

    localparam int NCH = CHANNELS_DEF;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [OUT_BITS-1:0] logical_levels;
        logic [OUT_BITS-1:0] pin_levels;
        logic [OUT_BITS-1:0] busy_mask;
        logic                rejected;
    } t_levels_snapshot;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [1:0]            i_func;
    logic [3:0]            i_channel;
    logic [CNT_W-1:0]      i_pulse_count;
    logic [HP_W-1:0]       i_half_period;
    logic                  i_level;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [OUT_BITS-1:0]   o_logical_levels;
    logic [OUT_BITS-1:0]   o_pin_levels;
    logic [OUT_BITS-1:0]   o_busy_mask;
    logic                  o_rejected;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    logic [CNT_W-1:0]    m_remaining [NCH];
    logic [HP_W-1:0]     m_period    [NCH];
    logic [HP_W-1:0]     m_countdown [NCH];
    logic                m_restart   [NCH];
    logic                m_invert    [NCH];
    logic                m_phase     [NCH];
    logic [OUT_BITS-1:0] m_levels;
    logic [HP_W-1:0]     m_default_hp;
    logic                m_active_low;

    t_levels_snapshot expected_levels [$];
    t_levels_snapshot head_levels;
    int unsigned      mismatch_count = 0;
    int unsigned      cycle_count = 0;

    multi_channel_pulse_train_generator_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_func          (i_func),
        .i_channel       (i_channel),
        .i_pulse_count   (i_pulse_count),
        .i_half_period   (i_half_period),
        .i_level         (i_level),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_logical_levels(o_logical_levels),
        .o_pin_levels    (o_pin_levels),
        .o_busy_mask     (o_busy_mask),
        .o_rejected      (o_rejected),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function void reset_generator_model();
        for (int c = 0; c < NCH; c++) begin
            m_remaining[c] = '0;
            m_period[c]    = '0;
            m_countdown[c] = '0;
            m_restart[c]   = 1'b0;
            m_invert[c]    = 1'b0;
            m_phase[c]     = 1'b0;
        end
        m_levels     = '0;
        m_default_hp = HP_RESET;
        m_active_low = ACTIVE_LOW_RESET;
    endfunction

    task automatic advance_generator_model(input t_func f, input logic [3:0] ch,
            input logic [CNT_W-1:0] cnt, input logic [HP_W-1:0] hp, input logic lvl);
        t_levels_snapshot snap;
        snap = '0;
        if (f == FUNC_TICK) begin
            for (int c = 0; c < NCH; c++) begin
                if (m_remaining[c] != 0) begin
                    if (m_countdown[c] != 0) begin
                        m_countdown[c] = m_countdown[c] - 1'b1;
                    end else begin
                        if (m_restart[c]) begin
                            m_phase[c]   = 1'b0;
                            m_restart[c] = 1'b0;
                        end
                        m_phase[c]  = ~m_phase[c];
                        m_levels[c] = m_invert[c] ? ~m_phase[c] : m_phase[c];
                        if (!m_phase[c]) begin
                            m_remaining[c] = m_remaining[c] - 1'b1;
                        end
                        m_countdown[c] = m_period[c];
                    end
                end
            end
        end else if (ch >= NCH) begin
            snap.rejected = 1'b1;
        end else if (f == FUNC_SET_LEVEL) begin
            m_levels[ch] = lvl;
        end else begin
            m_remaining[ch] = (cnt != 0) ? cnt : 16'd1;
            m_period[ch]    = (hp != 0) ? hp : m_default_hp;
            m_countdown[ch] = '0;
            m_restart[ch]   = 1'b1;
            m_invert[ch]    = (f == FUNC_START_INV);
        end
        for (int c = 0; c < NCH; c++) begin
            snap.busy_mask[c] = (m_remaining[c] != 0);
        end
        snap.logical_levels = m_levels;
        snap.pin_levels     = m_active_low ? ~m_levels : m_levels;
        expected_levels.push_back(snap);
    endtask

    task automatic send_cmd(input t_func f, input logic [3:0] ch,
            input logic [CNT_W-1:0] cnt, input logic [HP_W-1:0] hp, input logic lvl);
        i_in_valid    <= 1'b1;
        i_func        <= f;
        i_channel     <= ch;
        i_pulse_count <= cnt;
        i_half_period <= hp;
        i_level       <= lvl;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        advance_generator_model(f, ch, cnt, hp, lvl);
    endtask

    task automatic pause_sender(input int unsigned cycles);
        if (cycles != 0) begin
            i_in_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_levels.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic settle();
        drain_results();
        repeat (NCH + 4) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [CFG_DATA_W-1:0] default_hp,
            input logic [CFG_DATA_W-1:0] polarity_word);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_DEFAULT_HP;
        i_cfg_data  <= default_hp;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        m_default_hp = default_hp;
        i_cfg_index <= REG_ACTIVE_LOW;
        i_cfg_data  <= polarity_word;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        m_active_low = polarity_word[0];
        // unused index must leave both registers alone
        i_cfg_index <= $urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B;
        i_cfg_data  <= CFG_DATA_W'($urandom);
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_levels_after_reset();
        send_cmd(FUNC_TICK, 4'd0, 16'd0, 16'd0, 1'b0);
        send_cmd(FUNC_SET_LEVEL, 4'd0, 16'hFFFF, 16'hFFFF, 1'b1);
        send_cmd(FUNC_SET_LEVEL, 4'd10, 16'd0, 16'd0, 1'b1);
        send_cmd(FUNC_SET_LEVEL, 4'd10, 16'd0, 16'd0, 1'b0);
        send_cmd(FUNC_SET_LEVEL, 4'd15, 16'd0, 16'd0, 1'b1);
        send_cmd(FUNC_START_INV, 4'd11, 16'd5, 16'd1, 1'b0);
        settle();
    endtask

    task automatic test_default_period_burst();
        send_cmd(FUNC_START, 4'd3, 16'd0, 16'd0, 1'b0);
        send_cmd(FUNC_TICK, 4'd0, 16'd0, 16'd0, 1'b0);
        send_cmd(FUNC_TICK, 4'd15, 16'hFFFF, 16'hFFFF, 1'b1);
        settle();
    endtask

    task automatic test_zero_default_period();
        program_regs(16'd0, 16'hFFFE);
        send_cmd(FUNC_START, 4'd1, 16'd2, 16'd0, 1'b0);
        send_cmd(FUNC_START_INV, 4'd2, 16'd1, 16'd1, 1'b0);
        send_cmd(FUNC_TICK, 4'd0, 16'd0, 16'd0, 1'b0);
        send_cmd(FUNC_TICK, 4'd0, 16'd0, 16'd0, 1'b0);
        send_cmd(FUNC_TICK, 4'd0, 16'd0, 16'd0, 1'b0);
        send_cmd(FUNC_SET_LEVEL, 4'd1, 16'd0, 16'd0, 1'b0);
        send_cmd(FUNC_START, 4'd1, 16'hFFFF, 16'hFFFF, 1'b0);
        send_cmd(FUNC_TICK, 4'd0, 16'd0, 16'd0, 1'b0);
        send_cmd(FUNC_TICK, 4'd0, 16'd0, 16'd0, 1'b0);
        settle();
    endtask

    task automatic test_extreme_settings();
        program_regs(16'hFFFF, 16'h0001);
        send_cmd(FUNC_START, 4'd10, 16'd0, 16'd0, 1'b0);
        send_cmd(FUNC_START_INV, 4'd0, 16'hFFFF, 16'hFFFF, 1'b1);
        send_cmd(FUNC_TICK, 4'd0, 16'd0, 16'd0, 1'b0);
        settle();
    endtask

    task automatic run_random_phase(input logic [CFG_DATA_W-1:0] default_hp,
            input logic [CFG_DATA_W-1:0] polarity_word, input int unsigned count);
        int unsigned      pick;
        t_func            f;
        logic [3:0]       ch;
        logic [CNT_W-1:0] cnt;
        logic [HP_W-1:0]  hp;
        logic             lvl;
        settle();
        program_regs(default_hp, polarity_word);
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            ch   = 4'($urandom_range(0, NCH - 1));
            cnt  = CNT_W'($urandom);
            hp   = HP_W'($urandom);
            lvl  = 1'($urandom_range(0, 1));
            if (pick < 55) begin
                f  = FUNC_TICK;
                ch = 4'($urandom);
            end else if (pick < 80) begin
                f = $urandom_range(0, 3) == 0 ? FUNC_START_INV : FUNC_START;
                if ($urandom_range(0, 9) == 0) begin
                    ch = 4'($urandom_range(NCH, 15));
                end
                pick = $urandom_range(0, 9);
                if (pick < 7) begin
                    cnt = CNT_W'($urandom_range(0, 4));
                end else if (pick < 9) begin
                    cnt = CNT_W'($urandom_range(5, 50));
                end
                pick = $urandom_range(0, 19);
                if (pick < 8) begin
                    hp = '0;
                end else if (pick < 17) begin
                    hp = HP_W'($urandom_range(1, 4));
                end
            end else if (pick < 95) begin
                f = FUNC_SET_LEVEL;
                if ($urandom_range(0, 7) == 0) begin
                    ch = 4'($urandom_range(NCH, 15));
                end
            end else begin
                f  = t_func'($urandom_range(0, 3));
                ch = 4'($urandom);
            end
            if (n == count / 2) begin
                drain_results();
            end
            send_cmd(f, ch, cnt, hp, lvl);
            pause_sender((n >= 40 && n < 80) ? 0 : pick_gap());
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(16'd1, 16'h0000, 192);
        run_random_phase(16'd0, 16'h0001, 192);
        run_random_phase(16'd3, 16'hFFFF, 192);
        run_random_phase(16'hFFFF, 16'hFFFE, 192);
        run_random_phase(16'd2, 16'h8001, 192);
        run_random_phase(CFG_DATA_W'($urandom_range(0, 6)), CFG_DATA_W'($urandom), 192);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_levels.size() == 0) begin
                $error("result transaction with nothing expected");
                mismatch_count++;
            end else begin
                head_levels = expected_levels.pop_front();
                if (o_logical_levels !== head_levels.logical_levels) begin
                    $error("logical_levels: expected %h, actual %h",
                           head_levels.logical_levels, o_logical_levels);
                    mismatch_count++;
                end
                if (o_pin_levels !== head_levels.pin_levels) begin
                    $error("pin_levels: expected %h, actual %h",
                           head_levels.pin_levels, o_pin_levels);
                    mismatch_count++;
                end
                if (o_busy_mask !== head_levels.busy_mask) begin
                    $error("busy_mask: expected %h, actual %h",
                           head_levels.busy_mask, o_busy_mask);
                    mismatch_count++;
                end
                if (o_rejected !== head_levels.rejected) begin
                    $error("rejected: expected %b, actual %b",
                           head_levels.rejected, o_rejected);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        int unsigned run;
        i_out_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            run = pick_gap();
            if (run != 0) begin
                i_out_stall <= 1'b1;
                repeat (run) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            run = ($urandom_range(0, 24) == 0) ? $urandom_range(80, 200) : $urandom_range(1, 6);
            repeat (run) @(posedge i_clk);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_func        <= FUNC_TICK;
        i_channel     <= '0;
        i_pulse_count <= '0;
        i_half_period <= '0;
        i_level       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= REG_DEFAULT_HP;
        i_cfg_data    <= '0;
        reset_generator_model();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_levels_after_reset();
        test_default_period_burst();
        test_zero_default_period();
        test_extreme_settings();
        test_random_traffic();
        drain_results();
        repeat (NCH + 8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
